>>> design/rort_pkg.sv
// shared types and constants for the read-only region tracker
// no dependencies; used by every module in the design folder
package rort_pkg;

  localparam int ADDR_WIDTH  = 48;
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = 7;
  localparam int SHIFT_W     = 6;
  localparam int LIMIT_W     = 7;
  localparam int CMP_W       = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 7;

  // request kinds
  localparam logic [1:0] MODE_SHARED_READ = 2'd0;
  localparam logic [1:0] MODE_WRITE_MISS  = 2'd1;
  localparam logic [1:0] MODE_UPGRADE     = 2'd2;
  localparam logic [1:0] MODE_OTHER       = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REGION_SHIFT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_LIMIT  = CFG_IDX_W'(1);

  // configuration reset values
  localparam logic [SHIFT_W-1:0] REGION_SHIFT_RST = SHIFT_W'(6);
  localparam logic [LIMIT_W-1:0] ENTRY_LIMIT_RST  = LIMIT_W'(64);

  // aligned request held in the input register
  typedef struct packed {
    logic [ADDR_WIDTH-1:0] region;
    logic [1:0]            mode;
  } req_t;

  // lookup and update outcome for one request
  typedef struct packed {
    logic             hit;
    logic             inserted;
    logic             dropped;
    logic             region_read_only;
    logic [CNT_W-1:0] entry_count;
    logic [CNT_W-1:0] read_only_count;
    logic [CNT_W-1:0] written_count;
  } res_t;

endpackage

>>> design/rort_in_stage.sv
// input stage: aligns the address down to its region and registers the request
// depends on rort_pkg
module rort_in_stage (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rort_pkg::ADDR_WIDTH-1:0] in_req_address,
  input  logic [1:0]                     in_mode,
  input  logic [rort_pkg::SHIFT_W-1:0]   region_shift,
  input  logic                           advance,
  output logic                           req_valid,
  output rort_pkg::req_t                 req
);

  logic                  valid_r;
  logic                  valid_nxt;
  rort_pkg::req_t        req_r;
  rort_pkg::req_t        req_nxt;
  logic [rort_pkg::ADDR_WIDTH-1:0] mask;
  logic                  in_xfer;

  // room when empty or when the held request moves on this cycle
  assign in_ready = !valid_r || advance;
  assign in_xfer  = in_valid && in_ready;

  // shifts at or beyond the address width clear every bit
  assign mask = {rort_pkg::ADDR_WIDTH{1'b1}} << region_shift;

  always_comb begin
    req_nxt.region = in_req_address & mask;
    req_nxt.mode   = in_mode;
    if (in_xfer) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // request payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r <= req_nxt;
    end
  end

  assign req_valid = valid_r;
  assign req       = req_r;

endmodule

>>> design/rort_table.sv
// region table: parallel tag compare, insert at fill position, read-only marks
// and running counts; depends on rort_pkg
module rort_table (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         update,
  input  rort_pkg::req_t               req,
  input  logic [rort_pkg::LIMIT_W-1:0] entry_limit,
  output rort_pkg::res_t               res
);

  logic [rort_pkg::ADDR_WIDTH-1:0] tags_r [rort_pkg::TABLE_DEPTH];
  logic [rort_pkg::TABLE_DEPTH-1:0] valid_r;
  logic [rort_pkg::TABLE_DEPTH-1:0] ro_r;
  logic [rort_pkg::CNT_W-1:0]       held_r;
  logic [rort_pkg::CNT_W-1:0]       held_nxt;
  logic [rort_pkg::CNT_W-1:0]       ro_cnt_r;
  logic [rort_pkg::CNT_W-1:0]       ro_cnt_nxt;

  logic [rort_pkg::TABLE_DEPTH-1:0] match;
  logic                             hit;
  logic                             hit_ro;
  logic                             clear_ro;
  logic                             can_insert;
  logic                             do_insert;
  logic                             shared;
  logic [rort_pkg::IDX_W-1:0]       slot;

  // tag compare against every held entry
  always_comb begin
    for (int i = 0; i < rort_pkg::TABLE_DEPTH; i++) begin
      match[i] = valid_r[i] && (tags_r[i] == req.region);
    end
  end

  assign hit    = |match;
  assign hit_ro = |(match & ro_r);
  assign shared = (req.mode == rort_pkg::MODE_SHARED_READ);

  // decide hit update, insert or drop
  always_comb begin
    clear_ro   = hit && hit_ro &&
                 ((req.mode == rort_pkg::MODE_WRITE_MISS) ||
                  (req.mode == rort_pkg::MODE_UPGRADE));
    can_insert = (rort_pkg::CMP_W'(held_r) < rort_pkg::CMP_W'(entry_limit)) &&
                 (held_r < rort_pkg::CNT_W'(rort_pkg::TABLE_DEPTH));
    do_insert  = !hit && can_insert;
    slot       = held_r[rort_pkg::IDX_W-1:0];

    held_nxt   = held_r;
    ro_cnt_nxt = ro_cnt_r;
    if (do_insert) begin
      held_nxt = held_r + rort_pkg::CNT_W'(1);
      if (shared) begin
        ro_cnt_nxt = ro_cnt_r + rort_pkg::CNT_W'(1);
      end
    end else if (clear_ro) begin
      ro_cnt_nxt = ro_cnt_r - rort_pkg::CNT_W'(1);
    end

    res.hit              = hit;
    res.inserted         = do_insert;
    res.dropped          = !hit && !can_insert;
    res.region_read_only = hit ? (hit_ro && !clear_ro) : (do_insert && shared);
    res.entry_count      = held_nxt;
    res.read_only_count  = ro_cnt_nxt;
    res.written_count    = held_nxt - ro_cnt_nxt;
  end

  // counts and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= '0;
      ro_cnt_r <= '0;
      valid_r  <= '0;
    end else if (update) begin
      held_r   <= held_nxt;
      ro_cnt_r <= ro_cnt_nxt;
      if (do_insert) begin
        valid_r[slot] <= 1'b1;
      end
    end
  end

  // tags and read-only marks
  always_ff @(posedge clk) begin
    if (update) begin
      for (int i = 0; i < rort_pkg::TABLE_DEPTH; i++) begin
        if (do_insert && (slot == rort_pkg::IDX_W'(i))) begin
          tags_r[i] <= req.region;
          ro_r[i]   <= shared;
        end else if (clear_ro && match[i]) begin
          ro_r[i]   <= 1'b0;
        end
      end
    end
  end

endmodule

>>> design/read_only_region_tracker_core.sv
// read-only region tracker top level: config registers, input stage, table, result register
// path: an accepted request is held in the input register, looked up in the table, then captured in the result register
// throughput: one request per cycle while out_ready is high; table lookup and update happen as the request advances
// reset: clears table valid bits, counts and handshake state; config returns to defaults
// the table needs no clearing pass, so requests are taken right after reset
// depends on rort_pkg, rort_in_stage, rort_table
module read_only_region_tracker_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rort_pkg::ADDR_WIDTH-1:0]  in_req_address,
  input  logic [1:0]                       in_mode,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_hit,
  output logic                             out_inserted,
  output logic                             out_dropped,
  output logic                             out_region_read_only,
  output logic [rort_pkg::CNT_W-1:0]       out_entry_count,
  output logic [rort_pkg::CNT_W-1:0]       out_read_only_count,
  output logic [rort_pkg::CNT_W-1:0]       out_written_count,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rort_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rort_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [rort_pkg::SHIFT_W-1:0] region_shift_r;
  logic [rort_pkg::LIMIT_W-1:0] entry_limit_r;
  logic                         req_valid;
  rort_pkg::req_t               req;
  rort_pkg::res_t               res;
  rort_pkg::res_t               res_r;
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic                         advance;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_shift_r <= rort_pkg::REGION_SHIFT_RST;
      entry_limit_r  <= rort_pkg::ENTRY_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rort_pkg::REG_REGION_SHIFT: region_shift_r <= cfg_data[rort_pkg::SHIFT_W-1:0];
        rort_pkg::REG_ENTRY_LIMIT:  entry_limit_r  <= cfg_data[rort_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // request moves into the result register when that register is empty or its result is taken this cycle
  assign advance = req_valid && (!out_valid_r || out_ready);

  rort_in_stage u_in_stage (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_address (in_req_address),
    .in_mode        (in_mode),
    .region_shift   (region_shift_r),
    .advance        (advance),
    .req_valid      (req_valid),
    .req            (req)
  );

  rort_table u_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .update      (advance),
    .req         (req),
    .entry_limit (entry_limit_r),
    .res         (res)
  );

  // result register
  always_comb begin
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_hit              = res_r.hit;
  assign out_inserted         = res_r.inserted;
  assign out_dropped          = res_r.dropped;
  assign out_region_read_only = res_r.region_read_only;
  assign out_entry_count      = res_r.entry_count;
  assign out_read_only_count  = res_r.read_only_count;
  assign out_written_count    = res_r.written_count;

endmodule
